@@ rtl/sibl_pkg.sv @@
`default_nettype none

package sibl_pkg;

  // datapath widths
  localparam int unsigned SIZE_WIDTH = 48;
  localparam int unsigned CELL_W     = 25;
  localparam int unsigned UNITS_W    = 6;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned STRIPE_W   = CELL_W + UNITS_W;

  // full-stripe product is split in two halves to keep multipliers narrow
  localparam int unsigned LO_W = SIZE_WIDTH / 2;
  localparam int unsigned HI_W = SIZE_WIDTH - LO_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CELL_W;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DATA_UNITS = CFG_IDX_W'(1);

  localparam logic [CELL_W-1:0]   CELL_RESET  = CELL_W'(1048576);
  localparam logic [UNITS_W-1:0]  UNITS_RESET = UNITS_W'(6);
  localparam logic [STRIPE_W-1:0] STRIPE_RESET = STRIPE_W'(1048576 * 6);

  // one restoring division step: partial remainder plus a shared
  // dividend / quotient shift word
  typedef struct packed {
    logic [STRIPE_W-1:0]   rem;
    logic [SIZE_WIDTH-1:0] nq;
  } div_t;

  function automatic div_t div_step(input logic [STRIPE_W-1:0]   rem,
                                    input logic [SIZE_WIDTH-1:0] nq,
                                    input logic [STRIPE_W-1:0]   divisor);
    logic [STRIPE_W:0] trial;
    logic              ge;
    div_t              res;
    trial = {rem, nq[SIZE_WIDTH-1]};
    ge    = (trial >= {1'b0, divisor});
    if (ge) begin
      trial = trial - {1'b0, divisor};
    end
    res.rem = trial[STRIPE_W-1:0];
    res.nq  = {nq[SIZE_WIDTH-2:0], ge};
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/striped_internal_block_length_core.sv @@
`default_nettype none

// throughput: one beat per cycle while the output is not stalled, set by the 48-step
// pipelined restoring divider (one quotient bit per stage) followed by two multiply/add
// stages and an output register; stalls collapse bubbles stage by stage, so new beats
// enter while a result waits; reset (rst_ni low, asynchronous) empties the pipeline and
// restores cell_size 1048576, data_units 6; no clearing pass is needed
module striped_internal_block_length_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [sibl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [sibl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [sibl_pkg::SIZE_WIDTH-1:0]      group_bytes_i,
  input  wire logic [sibl_pkg::INDEX_W-1:0]         unit_index_i,
  // output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [sibl_pkg::SIZE_WIDTH-1:0]           unit_bytes_o
);

  localparam int unsigned N = sibl_pkg::SIZE_WIDTH;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [sibl_pkg::CELL_W-1:0]   cell_q;
  logic [sibl_pkg::UNITS_W-1:0]  units_q;
  logic [sibl_pkg::STRIPE_W-1:0] stripe_q;
  logic                          cfg_bad;

  assign cfg_ready_o = 1'b1;
  // a zero cell size or zero unit count makes every length zero
  assign cfg_bad     = (cell_q == '0) || (units_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q   <= sibl_pkg::CELL_RESET;
      units_q  <= sibl_pkg::UNITS_RESET;
      stripe_q <= sibl_pkg::STRIPE_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sibl_pkg::REG_CELL_SIZE:  cell_q  <= cfg_data_i[sibl_pkg::CELL_W-1:0];
          sibl_pkg::REG_DATA_UNITS: units_q <= cfg_data_i[sibl_pkg::UNITS_W-1:0];
          default: ;
        endcase
      end
      // stripe size follows the registers in the cycle after; the user must change config only
      // while the pipe is empty (the block does not enforce this), so the lag never shows
      stripe_q <= cell_q * units_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic       out_v_q, p2_v_q, p1_v_q;
  logic       en_out, en_p2, en_p1;
  logic [N:0] v_q;
  logic [N:0] en;

  assign en_out = !out_v_q || !out_stall_i;
  assign en_p2  = !p2_v_q || en_out;
  assign en_p1  = !p1_v_q || en_p2;
  assign en[N]  = !v_q[N] || en_p1;

  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign in_stall_o = !en[0];

  // ---------------------------------------------------------------------------
  // stage 0 and divider stages 1..N: group_bytes / stripe, one bit per stage
  // ---------------------------------------------------------------------------
  logic [sibl_pkg::SIZE_WIDTH-1:0] nq_q  [0:N];
  logic [sibl_pkg::STRIPE_W-1:0]   rem_q [0:N];
  logic [sibl_pkg::INDEX_W-1:0]    idx_q [0:N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      nq_q[0]  <= group_bytes_i;
      rem_q[0] <= '0;
      idx_q[0] <= unit_index_i;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_div
    sibl_pkg::div_t step_d;

    always_comb begin
      step_d = sibl_pkg::div_step(rem_q[k-1], nq_q[k-1], stripe_q);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        nq_q[k]  <= step_d.nq;
        rem_q[k] <= step_d.rem;
        idx_q[k] <= idx_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage p1: full stripes times cell size as two half products, and the
  // byte offset of the unit inside the last stripe
  // ---------------------------------------------------------------------------
  logic [sibl_pkg::LO_W+sibl_pkg::CELL_W-1:0] lo_prod;
  logic [sibl_pkg::HI_W+sibl_pkg::CELL_W-1:0] hi_prod;
  logic [sibl_pkg::STRIPE_W-1:0]              before_d;

  logic [sibl_pkg::LO_W+sibl_pkg::CELL_W-1:0] p1_lo_q;
  logic [sibl_pkg::HI_W-1:0]                  p1_hi_q;
  logic [sibl_pkg::STRIPE_W-1:0]              p1_rem_q;
  logic [sibl_pkg::STRIPE_W-1:0]              p1_before_q;
  logic                                       p1_parity_q;

  assign lo_prod  = nq_q[N][sibl_pkg::LO_W-1:0] * cell_q;
  assign hi_prod  = nq_q[N][sibl_pkg::SIZE_WIDTH-1:sibl_pkg::LO_W] * cell_q;
  assign before_d = idx_q[N] * cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en_p1) begin
      p1_v_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p1) begin
      p1_lo_q     <= lo_prod;
      // only the low HI_W bits of the upper product survive the size wrap
      p1_hi_q     <= hi_prod[sibl_pkg::HI_W-1:0];
      p1_rem_q    <= rem_q[N];
      p1_before_q <= before_d;
      p1_parity_q <= (idx_q[N] >= units_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage p2: recombine the full-stripe length, work out the last-cell share
  // ---------------------------------------------------------------------------
  logic [sibl_pkg::SIZE_WIDTH:0]   base_sum;
  logic [sibl_pkg::STRIPE_W-1:0]   share_raw;
  logic [sibl_pkg::CELL_W-1:0]     share_d;
  logic [sibl_pkg::SIZE_WIDTH-1:0] p2_base_q;
  logic [sibl_pkg::CELL_W-1:0]     p2_share_q;

  assign base_sum = {1'b0, sibl_pkg::SIZE_WIDTH'(p1_lo_q)}
                  + {1'b0, p1_hi_q, {sibl_pkg::LO_W{1'b0}}};

  always_comb begin
    // parity units take the remainder; data units what is left past their offset
    if (p1_parity_q) begin
      share_raw = p1_rem_q;
    end else if (p1_rem_q > p1_before_q) begin
      share_raw = p1_rem_q - p1_before_q;
    end else begin
      share_raw = '0;
    end
    // at most one cell; a zero remainder gives a zero share on its own
    if (share_raw > sibl_pkg::STRIPE_W'(cell_q)) begin
      share_d = cell_q;
    end else begin
      share_d = share_raw[sibl_pkg::CELL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en_p2) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p2) begin
      p2_base_q  <= base_sum[sibl_pkg::SIZE_WIDTH-1:0];
      p2_share_q <= share_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [sibl_pkg::SIZE_WIDTH:0]   unit_sum;
  logic [sibl_pkg::SIZE_WIDTH-1:0] unit_d;
  logic [sibl_pkg::SIZE_WIDTH-1:0] unit_q;

  assign unit_sum = {1'b0, p2_base_q} + {1'b0, sibl_pkg::SIZE_WIDTH'(p2_share_q)};
  assign unit_d   = cfg_bad ? '0 : unit_sum[sibl_pkg::SIZE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      unit_q <= unit_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign unit_bytes_o = unit_q;

`ifndef SYNTH
  // input only backs up when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && p2_v_q && p1_v_q))
    else $error("input stalled with a free pipeline slot");

  // a result only shows up after the last arithmetic stage held a beat
  a_out_from_p2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(p2_v_q))
    else $error("result beat without a source");

  // a legal setting never yields a zero stripe divisor
  a_stripe_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cell_q != '0 && units_q != '0) |-> (stripe_q != '0))
    else $error("stripe size zero under a legal setting");
`endif

endmodule

`default_nettype wire
